// ===== rtl/rspt_pkg.sv =====
// Shared types, constants and saturating arithmetic for the step profile table.
// Depends on nothing; imported by every module of the block except rspt_ram.
package rspt_pkg;

   localparam int TABLE_DEPTH = 64;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 3);
   localparam int TIME_W      = 32;
   localparam int AMT_W       = 48;
   localparam int ENTRY_W     = TIME_W + AMT_W;

   localparam logic [TIME_W-1:0] TIME_SAT_MAX = 32'hFFFF_FFFF;
   localparam logic signed [AMT_W-1:0] AMT_ZERO = '0;
   localparam logic signed [AMT_W-1:0] AMT_MAX  = {1'b0, {(AMT_W-1){1'b1}}};
   localparam logic signed [AMT_W-1:0] AMT_MIN  = {1'b1, {(AMT_W-1){1'b0}}};

   localparam logic [1:0] KIND_ADD   = 2'd0;
   localparam logic [1:0] KIND_MAX   = 2'd1;
   localparam logic [1:0] KIND_BELOW = 2'd2;

   localparam logic [1:0] STATUS_DONE    = 2'd0;
   localparam logic [1:0] STATUS_FULL    = 2'd1;
   localparam logic [1:0] STATUS_IGNORED = 2'd2;

   typedef struct packed {
      logic load;
      logic step;
      logic commit;
   } dp_cmd_type;

   typedef struct packed {
      logic done;
      logic consume;
   } dp_stat_type;

   // clamp a 49-bit sum to the signed 48-bit range
   function automatic logic signed [AMT_W-1:0] sat_amt(input logic signed [AMT_W:0] s);
      logic signed [AMT_W-1:0] r;
      if (s[AMT_W] != s[AMT_W-1]) begin
         r = s[AMT_W] ? AMT_MIN : AMT_MAX;
      end else begin
         r = s[AMT_W-1:0];
      end
      return r;
   endfunction

endpackage

// ===== rtl/rspt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module rspt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/rspt_ctrl.sv =====
// Sequencer for the step profile table: accept, fetch/evaluate walk, respond.
// Depends on rspt_pkg for the command and status structs.
module rspt_ctrl import rspt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_fire,
   input  logic        out_free,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd,
   output logic        idle,
   output logic        resp_load
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_FETCH = 4'b0010,
      ST_EVAL  = 4'b0100,
      ST_RESP  = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_fire) state_in = ST_FETCH;
         ST_FETCH: state_in = ST_EVAL;
         ST_EVAL: begin
            if (stat.done) begin
               state_in = ST_RESP;
            end else if (stat.consume) begin
               state_in = ST_FETCH;
            end
         end
         ST_RESP:  if (out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign idle       = (state_ff == ST_IDLE);
   assign cmd.load   = idle && req_fire;
   assign cmd.step   = (state_ff == ST_EVAL) && !stat.done;
   assign cmd.commit = (state_ff == ST_RESP) && out_free;
   assign resp_load  = cmd.commit;

endmodule

// ===== rtl/rspt_dp.sv =====
// Datapath: double-banked breakpoint table, merge/scan registers and result logic.
// Depends on rspt_pkg and rspt_ram.
module rspt_dp import rspt_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  dp_cmd_type              cmd,
   input  logic                    reservations_enabled,
   input  logic [1:0]              kind,
   input  logic [TIME_W-1:0]       origin_time,
   input  logic [TIME_W-1:0]       duration,
   input  logic signed [AMT_W-1:0] amount,
   output dp_stat_type             stat,
   output logic [1:0]              res_status,
   output logic signed [AMT_W-1:0] res_peak,
   output logic [TIME_W-1:0]       res_drop,
   output logic signed [AMT_W-1:0] res_tail
);

   logic [1:0]              kind_ff;
   logic [TIME_W-1:0]       start_ff, end_ff;
   logic signed [AMT_W-1:0] u_ff;
   logic                    add_ff, ign_ff;
   logic [CNT_W-1:0]        i_ff, m_ff, count_ff;
   logic                    sd_ff, ed_ff, bank_ff;
   logic signed [AMT_W-1:0] prev_old_ff, prev_new_ff, last_ff, best_ff, tail_ff;
   logic [TIME_W-1:0]       drop_ff;

   logic [ENTRY_W-1:0]      rd0, rd1, rd, wr_data;
   logic [TIME_W-1:0]       t, e_t, end_w;
   logic signed [AMT_W-1:0] a, e_a, sum_au, sum_pu, sub_pu;
   logic                    has, emit, set_sd, set_ed, wr, keep;
   logic [TIME_W:0]         end_sum;

   assign end_sum = {1'b0, origin_time} + {1'b0, duration};
   assign end_w   = (end_sum >= {1'b0, TIME_SAT_MAX}) ? TIME_SAT_MAX : end_sum[TIME_W-1:0];

   assign rd  = bank_ff ? rd1 : rd0;
   assign t   = rd[TIME_W-1:0];
   assign a   = rd[ENTRY_W-1:TIME_W];
   assign has = (i_ff < count_ff);

   assign sum_au = sat_amt({a[AMT_W-1], a} + {u_ff[AMT_W-1], u_ff});
   assign sum_pu = sat_amt({prev_old_ff[AMT_W-1], prev_old_ff} + {u_ff[AMT_W-1], u_ff});
   assign sub_pu = sat_amt({prev_new_ff[AMT_W-1], prev_new_ff} - {u_ff[AMT_W-1], u_ff});

   // merge step of an add: one breakpoint out per evaluation
   always_comb begin
      emit   = 1'b0;
      e_t    = t;
      e_a    = a;
      set_sd = 1'b0;
      set_ed = 1'b0;
      stat.consume = 1'b0;
      if (!sd_ff) begin
         if (has && t < start_ff) begin
            emit = 1'b1;
            stat.consume = 1'b1;
         end else if (has && t == start_ff) begin
            emit = 1'b1;
            e_a  = sum_au;
            set_sd = 1'b1;
            stat.consume = 1'b1;
         end else begin
            emit = 1'b1;
            e_t  = start_ff;
            e_a  = sum_pu;
            set_sd = 1'b1;
         end
      end else if (!ed_ff) begin
         if (has && t == end_ff) begin
            emit = 1'b1;
            set_ed = 1'b1;
            stat.consume = 1'b1;
         end else if (has && t < end_ff) begin
            emit = 1'b1;
            e_a  = sum_au;
            stat.consume = 1'b1;
         end else begin
            emit = 1'b1;
            e_t  = end_ff;
            e_a  = sub_pu;
            set_ed = 1'b1;
         end
      end else begin
         emit = has;
         stat.consume = has;
      end
      if (!add_ff) begin
         stat.consume = 1'b1;
      end
   end

   always_comb begin
      if (add_ff) begin
         stat.done = !has && sd_ff && ed_ff;
      end else if (kind_ff == KIND_MAX) begin
         stat.done = !has || (t > start_ff && t >= end_ff);
      end else if (kind_ff == KIND_BELOW) begin
         stat.done = !has;
      end else begin
         stat.done = 1'b1;
      end
   end

   assign keep    = (m_ff == '0) || (e_a != last_ff);
   assign wr      = cmd.step && add_ff && emit && keep && (m_ff < CNT_W'(TABLE_DEPTH));
   assign wr_data = {e_a, e_t};

   rspt_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_bank0 (
      .clock   (clock),
      .wr_en   (wr && bank_ff),
      .wr_addr (m_ff[ADDR_W-1:0]),
      .wr_data (wr_data),
      .rd_addr (i_ff[ADDR_W-1:0]),
      .rd_data (rd0)
   );

   rspt_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_bank1 (
      .clock   (clock),
      .wr_en   (wr && !bank_ff),
      .wr_addr (m_ff[ADDR_W-1:0]),
      .wr_data (wr_data),
      .rd_addr (i_ff[ADDR_W-1:0]),
      .rd_data (rd1)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         bank_ff  <= 1'b0;
         count_ff <= '0;
         tail_ff  <= AMT_ZERO;
         i_ff     <= '0;
         add_ff   <= 1'b0;
      end else if (cmd.load) begin
         kind_ff     <= kind;
         start_ff    <= origin_time;
         end_ff      <= end_w;
         u_ff        <= amount;
         add_ff      <= (kind == KIND_ADD) && reservations_enabled && (duration != '0)
                        && (end_w != origin_time);
         ign_ff      <= (kind == KIND_ADD) && (!reservations_enabled || duration == '0);
         i_ff        <= '0;
         m_ff        <= '0;
         sd_ff       <= 1'b0;
         ed_ff       <= 1'b0;
         prev_old_ff <= AMT_ZERO;
         best_ff     <= AMT_ZERO;
         drop_ff     <= '0;
      end else if (cmd.step) begin
         if (stat.consume) begin
            i_ff <= i_ff + CNT_W'(1);
         end
         if (add_ff) begin
            if (set_sd) sd_ff <= 1'b1;
            if (set_ed) ed_ff <= 1'b1;
            if (!sd_ff && !set_sd) prev_old_ff <= a;
            if (sd_ff || set_sd) prev_new_ff <= e_a;
            if (emit && keep) begin
               m_ff    <= m_ff + CNT_W'(1);
               last_ff <= e_a;
            end
         end else if (kind_ff == KIND_MAX) begin
            if (t <= start_ff || a > best_ff) best_ff <= a;
         end else begin
            if (i_ff != '0 && a <= u_ff && prev_old_ff > u_ff) drop_ff <= t;
            prev_old_ff <= a;
         end
      end else if (cmd.commit) begin
         if (add_ff && m_ff <= CNT_W'(TABLE_DEPTH)) begin
            bank_ff  <= !bank_ff;
            count_ff <= m_ff;
            tail_ff  <= last_ff;
         end
      end
   end

   always_comb begin
      if (ign_ff) begin
         res_status = STATUS_IGNORED;
      end else if (add_ff && m_ff > CNT_W'(TABLE_DEPTH)) begin
         res_status = STATUS_FULL;
      end else begin
         res_status = STATUS_DONE;
      end
   end

   assign res_peak = (kind_ff == KIND_MAX) ? best_ff : AMT_ZERO;
   assign res_drop = (kind_ff == KIND_BELOW) ? drop_ff : '0;
   // report the tail as it stands once this transaction is committed
   assign res_tail = (add_ff && m_ff <= CNT_W'(TABLE_DEPTH)) ? last_ff : tail_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_DEPTH))
      else $error("breakpoint count exceeds table depth");

   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> i_ff <= count_ff)
      else $error("walk index beyond valid breakpoints");

   a_commit_count: assert property (@(posedge clock) disable iff (reset)
      cmd.commit && add_ff && res_status == STATUS_DONE |=> count_ff == $past(m_ff))
      else $error("committed add did not update breakpoint count");

endmodule

// ===== rtl/resource_step_profile_table.sv =====
// Top level of the resource step profile table: ports, config register, result register.
// Depends on rspt_pkg, rspt_ctrl, rspt_dp (and rspt_ram through rspt_dp).
//
// Keeps a time-sorted table of up to 64 breakpoints (time, signed Q32.16 amount) describing
// resource use as a step function. A request of kind 0 adds a rectangle over
// [start, start+duration), kind 1 returns the peak over that window, kind 2 returns the latest
// breakpoint where use drops to or below the amount given as threshold. One request is in
// work at a time: it walks the stored breakpoints once, each entry taking a RAM fetch then an
// evaluate, and an add spends one further evaluate for each new start or end point. An add
// writes its result into the spare bank of a double-banked RAM and swaps banks only when the
// table fits, so a refused add leaves the table untouched. The result sits in an output
// register, so the next request may be accepted while it waits. Write csr_wr_en only while
// no request is outstanding; the register resets to 1 (reservations on).
module resource_step_profile_table import rspt_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_wr_en,
   input  logic         csr_wr_data,     // reservations_enabled
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [119:0] req_tdata,       // kind[1:0], origin_time[33:2], duration[65:34],
                                         // amount[113:66], zero pad
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [135:0] rsp_tdata        // status[1:0], peak_amount[49:2], drop_time[81:50],
                                         // end_amount[129:82], zero pad
);

   logic                    enabled_ff;
   logic                    rsp_valid_ff;
   logic [135:0]            rsp_data_ff;
   logic                    idle, resp_load, out_free, req_fire;
   dp_cmd_type              cmd;
   dp_stat_type             stat;
   logic [1:0]              res_status;
   logic signed [AMT_W-1:0] res_peak, res_tail;
   logic [TIME_W-1:0]       res_drop;

   // hold the config bit; the user must write it only while idle, the block does not enforce it
   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff <= 1'b1;
      end else if (csr_wr_en) begin
         enabled_ff <= csr_wr_data;
      end
   end

   assign req_tready = idle;
   assign req_fire   = req_tvalid && idle;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   rspt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_fire  (req_fire),
      .out_free  (out_free),
      .stat      (stat),
      .cmd       (cmd),
      .idle      (idle),
      .resp_load (resp_load)
   );

   rspt_dp u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .reservations_enabled (enabled_ff),
      .kind                 (req_tdata[1:0]),
      .origin_time          (req_tdata[33:2]),
      .duration             (req_tdata[65:34]),
      .amount               (req_tdata[113:66]),
      .stat                 (stat),
      .res_status           (res_status),
      .res_peak             (res_peak),
      .res_drop             (res_drop),
      .res_tail             (res_tail)
   );

   // result register: load on completion, drop valid once the transaction is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (resp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (resp_load) begin
         rsp_data_ff <= {6'd0, res_tail, res_drop, res_peak, res_status};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== test/resource_step_profile_table_test.sv =====
// Self-checking bench for resource_step_profile_table: drives stream requests, predicts
// every response from its own copy of the breakpoint table, compares field by field.
// Depends on rspt_pkg and the resource_step_profile_table RTL.
`timescale 1ns / 100ps

module resource_step_profile_table_test;
   import rspt_pkg::*;

   localparam logic [1:0] KIND_SPARE = 2'd3;   // unused kind, must change nothing
   localparam int STALL_LIMIT = 20000;          // cycles with no transaction before giving up
   localparam int LONG_HOLD   = 400;            // receiver hold-off to fill the block up

   typedef struct packed {
      logic [1:0]        kind;
      logic [31:0]       origin_time;
      logic [31:0]       duration;
      logic [AMT_W-1:0]  amount;
   } request_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [AMT_W-1:0]  peak_amount;
      logic [31:0]       drop_time;
      logic [AMT_W-1:0]  end_amount;
   } response_type;

   logic         clock       = 1'b0;
   logic         reset       = 1'b1;
   logic         csr_wr_en   = 1'b0;
   logic         csr_wr_data = 1'b1;
   logic         req_tvalid  = 1'b0;
   logic         req_tready;
   logic [119:0] req_tdata   = '0;   // kind, origin_time, duration, amount, zero pad
   logic         rsp_tvalid;
   logic         rsp_tready  = 1'b0;
   logic [135:0] rsp_tdata;          // status, peak_amount, drop_time, end_amount, zero pad

   resource_step_profile_table uut (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Shadow copy of the breakpoint table and the booking switch
   logic [31:0]      prof_time   [0:TABLE_DEPTH-1];
   longint           prof_amount [0:TABLE_DEPTH-1];
   int               prof_count  = 0;
   logic             booking_on  = 1'b1;

   // Scratch table for an add, two spare slots for the new start and end points
   logic [31:0]      draft_time   [0:TABLE_DEPTH+1];
   longint           draft_amount [0:TABLE_DEPTH+1];

   request_type      pending_requests[$];
   response_type     awaited_responses[$];
   request_type      booked_adds[$];     // adds that took effect, candidates for undoing

   request_type      offered;
   int               send_gap     = 0;
   int               hold_left    = 0;
   bit               held_long    = 0;
   bit               calm         = 0;   // no idling on either side
   int               taken_count  = 0;
   int               error_count  = 0;
   int               quiet_cycles = 0;

   function automatic longint widen(input logic [AMT_W-1:0] a);
      return longint'(signed'(a));
   endfunction

   function automatic longint clamp_amount(input longint s);
      if (s > widen(AMT_MAX)) return widen(AMT_MAX);
      if (s < widen(AMT_MIN)) return widen(AMT_MIN);
      return s;
   endfunction

   function automatic logic [31:0] window_stop(input logic [31:0] s, input logic [31:0] d);
      longint e;
      e = longint'(s) + longint'(d);
      return (e >= 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : e[31:0];
   endfunction

   // open a slot at pos in the draft table and drop the breakpoint in
   task automatic draft_insert(input int n, input int pos, input logic [31:0] t,
                               input longint a);
      int k;
      for (k = n; k > pos; k--) begin
         draft_time[k]   = draft_time[k-1];
         draft_amount[k] = draft_amount[k-1];
      end
      draft_time[pos]   = t;
      draft_amount[pos] = a;
   endtask

   // raise [s, e) by u; returns the status the block should report
   task automatic book_rectangle(input logic [31:0] s, input logic [31:0] e, input longint u,
                                 output logic [1:0] status);
      int n, i, j, m, k;
      bit found;
      longint prev;
      n = prof_count;
      found = 0;
      for (k = 0; k < n; k++) begin
         draft_time[k]   = prof_time[k];
         draft_amount[k] = prof_amount[k];
      end
      i = 0;
      while (i < n && draft_time[i] < s) i++;
      if (i < n && draft_time[i] == s) begin
         draft_amount[i] = clamp_amount(draft_amount[i] + u);
      end else begin
         draft_insert(n, i, s, clamp_amount(u + ((i > 0) ? draft_amount[i-1] : 0)));
         n++;
      end
      // raise every breakpoint strictly inside the rectangle
      j = i + 1;
      while (j < n) begin
         if (draft_time[j] == e) begin
            found = 1;
            break;
         end
         if (e < draft_time[j]) break;
         draft_amount[j] = clamp_amount(draft_amount[j] + u);
         j++;
      end
      if (!found) begin
         draft_insert(n, j, e, clamp_amount(draft_amount[j-1] - u));
         n++;
      end
      // merge runs of equal amounts, keeping the first entry always
      m = 1;
      prev = draft_amount[0];
      for (k = 1; k < n; k++) begin
         if (draft_amount[k] != prev) begin
            prev = draft_amount[k];
            draft_time[m]   = draft_time[k];
            draft_amount[m] = draft_amount[k];
            m++;
         end
      end
      if (m > TABLE_DEPTH) begin
         status = STATUS_FULL;
      end else begin
         for (k = 0; k < m; k++) begin
            prof_time[k]   = draft_time[k];
            prof_amount[k] = draft_amount[k];
         end
         prof_count = m;
         status = STATUS_DONE;
      end
   endtask

   // peak use over [s, e); use before the first breakpoint counts as zero
   function automatic longint window_peak(input logic [31:0] s, input logic [31:0] e);
      int i;
      longint best;
      i = 0;
      best = 0;
      while (i < prof_count && prof_time[i] < s) i++;
      if (i < prof_count && prof_time[i] == s) begin
         best = prof_amount[i];
         i++;
      end else if (i > 0) begin
         best = prof_amount[i-1];
      end
      while (i < prof_count && e > prof_time[i]) begin
         if (prof_amount[i] > best) best = prof_amount[i];
         i++;
      end
      return best;
   endfunction

   // latest breakpoint where use steps from above the threshold to at or under it
   function automatic logic [31:0] latest_drop(input longint thr);
      int k;
      for (k = prof_count - 1; k > 0; k--) begin
         if (prof_amount[k] <= thr && prof_amount[k-1] > thr) return prof_time[k];
      end
      return 32'd0;
   endfunction

   // work out the response to one accepted request and update the shadow table
   task automatic apply_request(input request_type r);
      response_type rsp;
      logic [31:0]  stop_t;
      logic [1:0]   st;
      rsp = '0;
      stop_t = window_stop(r.origin_time, r.duration);
      case (r.kind)
         KIND_ADD: begin
            if (!booking_on || r.duration == 0) begin
               rsp.status = STATUS_IGNORED;
            end else if (stop_t != r.origin_time) begin
               book_rectangle(r.origin_time, stop_t, widen(r.amount), st);
               rsp.status = st;
               if (st == STATUS_DONE) booked_adds.push_back(r);
            end
         end
         KIND_MAX:   rsp.peak_amount = AMT_W'(window_peak(r.origin_time, stop_t));
         KIND_BELOW: rsp.drop_time = latest_drop(widen(r.amount));
         default: ;
      endcase
      if (prof_count > 0) rsp.end_amount = AMT_W'(prof_amount[prof_count-1]);
      awaited_responses.push_back(rsp);
   endtask

   // Driver: at most one nonblocking assignment to req_tvalid per edge, whatever branch runs
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            apply_request(offered);
            taken_count++;
         end
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (pending_requests.size() == 0) begin
               req_tvalid <= 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
               // idle burst whose length send_gap sets, this edge included
               send_gap = $urandom_range(0, 5);
               req_tvalid <= 1'b0;
            end else begin
               offered = pending_requests.pop_front();
               req_tdata  <= {6'b0, offered.amount, offered.duration, offered.origin_time,
                              offered.kind};
               req_tvalid <= 1'b1;
            end
         end
      end
   end

   // Receiver readiness: random stall bursts, and one long hold-off to back the block up
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (!held_long && taken_count >= 250) begin
         held_long = 1;
         hold_left = LONG_HOLD;
         rsp_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
         hold_left = $urandom_range(0, 5);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Monitor: compare each response transaction against the oldest prediction
   always @(posedge clock) begin
      response_type got, want;
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("resource_step_profile_table_test failed");
            $finish;
         end
         if (rsp_tvalid && rsp_tready) begin
            got = '{status: rsp_tdata[1:0], peak_amount: rsp_tdata[49:2],
                    drop_time: rsp_tdata[81:50], end_amount: rsp_tdata[129:82]};
            if (awaited_responses.size() == 0) begin
               $display("%0t: unexpected response %h", $time, rsp_tdata);
               error_count++;
            end else begin
               want = awaited_responses.pop_front();
               if (got.status != want.status) begin
                  $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
                  error_count++;
               end
               if (got.peak_amount != want.peak_amount) begin
                  $display("%0t: peak_amount expected %h got %h", $time,
                           want.peak_amount, got.peak_amount);
                  error_count++;
               end
               if (got.drop_time != want.drop_time) begin
                  $display("%0t: drop_time expected %h got %h", $time,
                           want.drop_time, got.drop_time);
                  error_count++;
               end
               if (got.end_amount != want.end_amount) begin
                  $display("%0t: end_amount expected %h got %h", $time,
                           want.end_amount, got.end_amount);
                  error_count++;
               end
            end
         end
      end
   end

   task automatic queue_request(input logic [1:0] k, input logic [31:0] s,
                                input logic [31:0] d, input logic [AMT_W-1:0] a);
      request_type r;
      r = '{kind: k, origin_time: s, duration: d, amount: a};
      // keep the feed short so undo picks see an up-to-date booking list
      while (pending_requests.size() > 3) @(posedge clock);
      pending_requests.push_back(r);
   endtask

   // hold until every request is sent and every response is back
   task automatic drain;
      while (pending_requests.size() != 0 || req_tvalid || awaited_responses.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_booking(input logic on);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= on;
      booking_on  = on;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   function automatic logic [AMT_W-1:0] pick_amount;
      if ($urandom_range(0, 9) == 0) return AMT_W'({$urandom, $urandom});
      return AMT_W'(int'($urandom_range(0, 64)) - 32) << 16;
   endfunction

   function automatic logic [31:0] pick_start;
      if ($urandom_range(0, 9) == 0) return $urandom;
      return $urandom_range(0, 4000);
   endfunction

   function automatic logic [31:0] pick_length;
      case ($urandom_range(0, 19))
         0:       return 32'd0;
         1:       return $urandom;
         default: return $urandom_range(1, 600);
      endcase
   endfunction

   // random traffic, mostly adds and their undos so the table grows, fills and shrinks
   task automatic random_traffic(input int count);
      int i, pick, idx;
      request_type r;
      for (i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         if (prof_count > 50 && pick < 40) pick = pick + 40;
         if (pick < 40) begin
            queue_request(KIND_ADD, pick_start(), pick_length(), pick_amount());
         end else if (pick < 62 && booked_adds.size() > 0) begin
            // undo an earlier add by booking its negative
            idx = $urandom_range(0, booked_adds.size() - 1);
            r = booked_adds[idx];
            booked_adds.delete(idx);
            queue_request(KIND_ADD, r.origin_time, r.duration, -r.amount);
         end else if (pick < 80) begin
            queue_request(KIND_MAX, pick_start(), pick_length(), pick_amount());
         end else if (pick < 96) begin
            queue_request(KIND_BELOW, pick_start(), pick_length(), pick_amount());
         end else begin
            queue_request(KIND_SPARE, $urandom, $urandom, AMT_W'({$urandom, $urandom}));
         end
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      set_booking(1'b1);

      // directed: empty table, window before the first breakpoint, saturation, edge times
      queue_request(KIND_MAX, 32'd0, 32'd10, '0);
      queue_request(KIND_BELOW, 32'd0, 32'd0, '0);
      queue_request(KIND_ADD, 32'd1000, 32'd100, AMT_W'(5) << 16);
      queue_request(KIND_MAX, 32'd0, 32'd2000, '0);
      queue_request(KIND_MAX, 32'd0, 32'd500, '0);
      queue_request(KIND_BELOW, 32'd0, 32'd0, '0);
      queue_request(KIND_BELOW, 32'd0, 32'd0, AMT_MIN);
      queue_request(KIND_ADD, 32'd500, 32'd0, AMT_W'(3) << 16);
      queue_request(KIND_ADD, 32'hFFFF_FFFF, 32'd7, AMT_W'(3) << 16);
      queue_request(KIND_ADD, 32'd0, 32'hFFFF_FFFF, AMT_MAX);
      queue_request(KIND_ADD, 32'd1050, 32'd20, AMT_MAX);
      queue_request(KIND_MAX, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0);
      queue_request(KIND_ADD, 32'd20, 32'd30, AMT_MIN);
      queue_request(KIND_ADD, 32'd20, 32'd30, AMT_MIN);
      queue_request(KIND_ADD, 32'hFFFF_FF00, 32'hFFFF_FFFF, AMT_W'(-1));
      queue_request(KIND_BELOW, 32'd0, 32'd0, AMT_MAX);
      queue_request(KIND_BELOW, 32'd0, 32'd0, AMT_W'(0));
      queue_request(KIND_SPARE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, AMT_MIN);
      queue_request(KIND_MAX, 32'd10, 32'd4000, '0);
      drain();

      // reservations off: adds ignored, queries still answered
      set_booking(1'b0);
      queue_request(KIND_ADD, 32'd5, 32'd10, AMT_W'(1) << 16);
      queue_request(KIND_ADD, 32'd5, 32'd0, AMT_W'(1) << 16);
      queue_request(KIND_MAX, 32'd0, 32'hFFFF_FFFF, '0);
      drain();

      set_booking(1'b1);
      random_traffic(950);
      drain();

      set_booking(1'b0);
      random_traffic(150);
      drain();

      set_booking(1'b1);
      random_traffic(400);
      calm = 1;
      random_traffic(150);
      drain();

      repeat (200) @(posedge clock);
      if (error_count == 0 && awaited_responses.size() == 0) begin
         $display("resource_step_profile_table_test passed");
      end else begin
         $display("resource_step_profile_table_test failed");
      end
      $finish;
   end

endmodule

// ===== resource_step_profile_table.f =====
rtl/rspt_pkg.sv
rtl/rspt_ram.sv
rtl/rspt_ctrl.sv
rtl/rspt_dp.sv
rtl/resource_step_profile_table.sv
test/resource_step_profile_table_test.sv
